[rtl/core/hvt_pkg.sv]
`timescale 1ns / 1ps
package hvt_pkg;

  // Q(32-F).F fixed-point word
  typedef logic signed [31:0] fx_t;

  localparam int FRAC_BITS_DEF = 16;
  localparam int NUM_REGS      = 8;
  localparam int CFG_ADDR_W    = 4;

  // register indexes that carry the identity at reset
  localparam logic [2:0] REG_ROW0_C01 = 3'd0;
  localparam logic [2:0] REG_ROW1_C01 = 3'd2;
  localparam logic [2:0] REG_ROW2_C23 = 3'd5;
  localparam logic [2:0] REG_ROW3_C23 = 3'd7;

  // divider: quotient bits resolved per pipeline stage
  localparam int DIV_STEPS  = 2;
  localparam int DIV_STAGES = 32 / DIV_STEPS;
  localparam int DIV_LAT    = DIV_STAGES + 1;

  localparam logic signed [31:0] FX_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] FX_MIN = 32'sh80000000;

  // clamp a wide signed value to 32 bits
  function automatic fx_t sat_fx(input logic signed [65:0] v);
    fx_t r;
    if (v > 66'(FX_MAX)) r = FX_MAX;
    else if (v < 66'(FX_MIN)) r = FX_MIN;
    else r = v[31:0];
    return r;
  endfunction

endpackage

[rtl/core/hvt_div_lane.sv]
`timescale 1ns / 1ps
module hvt_div_lane #(
  parameter int FRAC_BITS = hvt_pkg::FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         adv,
  input  hvt_pkg::fx_t c_i,
  input  hvt_pkg::fx_t w_i,
  output hvt_pkg::fx_t q_o
);
  import hvt_pkg::*;

  logic [31:0] abs_c, abs_w;
  logic [FRAC_BITS-1:0] hi;
  logic [31:0] lo;

  logic [31:0] rem_r [DIV_LAT];
  logic [31:0] nb_r  [DIV_LAT];
  logic [31:0] q_r   [DIV_LAT];
  logic [31:0] d_r   [DIV_LAT];
  logic        ovf_r [DIV_LAT];
  logic        neg_r [DIV_LAT];

  // magnitudes; dividend is |c| << FRAC_BITS split at bit 32
  always_comb begin
    abs_c = c_i[31] ? (~c_i + 32'd1) : c_i;
    abs_w = w_i[31] ? (~w_i + 32'd1) : w_i;
    hi    = abs_c[31 -: FRAC_BITS];
    lo    = {abs_c[31-FRAC_BITS:0], {FRAC_BITS{1'b0}}};
  end

  // setup stage: quotient of 2^32 or more only needs a compare
  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r[0] <= 32'(hi);
      nb_r[0]  <= lo;
      q_r[0]   <= '0;
      d_r[0]   <= abs_w;
      ovf_r[0] <= 32'(hi) >= abs_w;
      neg_r[0] <= c_i[31] ^ w_i[31];
    end
  end

  // restoring steps, DIV_STEPS bits per stage
  for (genvar k = 1; k < DIV_LAT; k++) begin : g_stage
    logic [31:0] rem_nxt, nb_nxt, q_nxt;
    logic [32:0] t;
    always_comb begin
      rem_nxt = rem_r[k-1];
      nb_nxt  = nb_r[k-1];
      q_nxt   = q_r[k-1];
      t       = '0;
      for (int s = 0; s < DIV_STEPS; s++) begin
        t      = {rem_nxt, nb_nxt[31]};
        nb_nxt = {nb_nxt[30:0], 1'b0};
        if (t >= {1'b0, d_r[k-1]}) begin
          t     = t - {1'b0, d_r[k-1]};
          q_nxt = {q_nxt[30:0], 1'b1};
        end else begin
          q_nxt = {q_nxt[30:0], 1'b0};
        end
        rem_nxt = t[31:0];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[k] <= rem_nxt;
        nb_r[k]  <= nb_nxt;
        q_r[k]   <= q_nxt;
        d_r[k]   <= d_r[k-1];
        ovf_r[k] <= ovf_r[k-1];
        neg_r[k] <= neg_r[k-1];
      end
    end
  end

  // sign and saturation
  always_comb begin
    if (neg_r[DIV_LAT-1]) begin
      if (ovf_r[DIV_LAT-1] || q_r[DIV_LAT-1] > 32'h80000000) q_o = FX_MIN;
      else q_o = 32'd0 - q_r[DIV_LAT-1];
    end else begin
      if (ovf_r[DIV_LAT-1] || q_r[DIV_LAT-1][31]) q_o = FX_MAX;
      else q_o = q_r[DIV_LAT-1];
    end
  end

endmodule

[rtl/core/homogeneous_vertex_transform.sv]
`timescale 1ns / 1ps
// channel  direction  handshake         payload
// in       input      in_valid/stall    in_x in_y in_z in_w in_project_point
// out      output     out_valid/stall   out_x out_y out_z out_w out_divide_fault
// cfg      input      cfg_valid/ready   cfg_addr cfg_data
//
// One request per cycle while out_stall does not hold the pipe; the perspective divider
// resolves 2 bits per stage.
// Synchronous active-low reset loads the identity matrix and empties the pipe.
// An output stall with a result held freezes every stage at once; nothing is lost or repeated.
module homogeneous_vertex_transform #(
  parameter int FRAC_BITS = hvt_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  hvt_pkg::fx_t                   in_x,
  input  hvt_pkg::fx_t                   in_y,
  input  hvt_pkg::fx_t                   in_z,
  input  hvt_pkg::fx_t                   in_w,
  input  logic                           in_project_point,
  output logic                           out_valid,
  input  logic                           out_stall,
  output hvt_pkg::fx_t                   out_x,
  output hvt_pkg::fx_t                   out_y,
  output hvt_pkg::fx_t                   out_z,
  output hvt_pkg::fx_t                   out_w,
  output logic                           out_divide_fault,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [hvt_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [63:0]                    cfg_data
);
  import hvt_pkg::*;

  localparam logic [63:0] ONE64 = 64'd1 << FRAC_BITS;
  localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [65:0] HALF = 66'sd1 <<< (FRAC_BITS - 1);

  logic [63:0] mat_r [NUM_REGS];
  fx_t elem [4][4];
  fx_t vec [4];
  logic adv;

  logic signed [63:0] prod_r [4][4];
  logic signed [64:0] pair_r [4][2];
  logic signed [65:0] sum_r [4];
  fx_t res_r [4];
  logic proj1_r, proj2_r, proj3_r, fault4_r, proj4_r;
  logic v1_r, v2_r, v3_r, v4_r;

  fx_t  dres_r [DIV_LAT][4];
  logic dfault_r [DIV_LAT];
  logic dproj_r [DIV_LAT];
  logic dv_r [DIV_LAT];
  fx_t  quo [3];

  logic out_valid_r, out_fault_r;
  fx_t  out_x_r, out_y_r, out_z_r, out_w_r;

  // whole pipe moves unless a result is held
  assign adv       = !(out_valid_r && out_stall);
  assign in_stall  = !adv;
  assign cfg_ready = 1'b1;

  // matrix registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < NUM_REGS; r++) begin
        case (3'(r))
          REG_ROW0_C01, REG_ROW2_C23: mat_r[r] <= ONE64;
          REG_ROW1_C01, REG_ROW3_C23: mat_r[r] <= ONE64 << 32;
          default: mat_r[r] <= '0;
        endcase
      end
    end else if (cfg_valid && cfg_addr < CFG_ADDR_W'(NUM_REGS)) begin
      mat_r[cfg_addr[2:0]] <= cfg_data;
    end
  end

  // element m(i,j) unpacking
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int c = 0; c < 2; c++) begin
        elem[i][2*c]   = mat_r[3'(2*i + c)][31:0];
        elem[i][2*c+1] = mat_r[3'(2*i + c)][63:32];
      end
    end
    vec[0] = in_x;
    vec[1] = in_y;
    vec[2] = in_z;
    vec[3] = in_project_point ? ONE : in_w;
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      for (int k = 0; k < DIV_LAT; k++) dv_r[k] <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      dv_r[0] <= v4_r;
      for (int k = 1; k < DIV_LAT; k++) dv_r[k] <= dv_r[k-1];
      out_valid_r <= dv_r[DIV_LAT-1];
    end
  end

  // stages 1-4: products, pair sums, full sum with rounding bias, shift and clamp
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 4; j++) begin
        for (int i = 0; i < 4; i++) prod_r[j][i] <= vec[i] * elem[i][j];
        pair_r[j][0] <= 65'(prod_r[j][0]) + 65'(prod_r[j][1]);
        pair_r[j][1] <= 65'(prod_r[j][2]) + 65'(prod_r[j][3]);
        sum_r[j]     <= 66'(pair_r[j][0]) + 66'(pair_r[j][1]) + HALF;
        res_r[j]     <= sat_fx(sum_r[j] >>> FRAC_BITS);
      end
      proj1_r  <= in_project_point;
      proj2_r  <= proj1_r;
      proj3_r  <= proj2_r;
      proj4_r  <= proj3_r;
      fault4_r <= proj3_r && (sat_fx(sum_r[3] >>> FRAC_BITS) == '0);
    end
  end

  // perspective divide lanes for x, y, z
  for (genvar j = 0; j < 3; j++) begin : g_div
    hvt_div_lane #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clk (clk),
      .adv (adv),
      .c_i (res_r[j]),
      .w_i (res_r[3]),
      .q_o (quo[j])
    );
  end

  // side data delay matched to the divider
  always_ff @(posedge clk) begin
    if (adv) begin
      dres_r[0]   <= res_r;
      dfault_r[0] <= fault4_r;
      dproj_r[0]  <= proj4_r;
      for (int k = 1; k < DIV_LAT; k++) begin
        dres_r[k]   <= dres_r[k-1];
        dfault_r[k] <= dfault_r[k-1];
        dproj_r[k]  <= dproj_r[k-1];
      end
    end
  end

  // output register: fault zeros, divide in project mode
  always_ff @(posedge clk) begin
    if (adv) begin
      out_fault_r <= dfault_r[DIV_LAT-1];
      if (dfault_r[DIV_LAT-1]) begin
        out_x_r <= '0;
        out_y_r <= '0;
        out_z_r <= '0;
        out_w_r <= '0;
      end else if (dproj_r[DIV_LAT-1]) begin
        out_x_r <= quo[0];
        out_y_r <= quo[1];
        out_z_r <= quo[2];
        out_w_r <= dres_r[DIV_LAT-1][3];
      end else begin
        out_x_r <= dres_r[DIV_LAT-1][0];
        out_y_r <= dres_r[DIV_LAT-1][1];
        out_z_r <= dres_r[DIV_LAT-1][2];
        out_w_r <= dres_r[DIV_LAT-1][3];
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_x            = out_x_r;
  assign out_y            = out_y_r;
  assign out_z            = out_z_r;
  assign out_w            = out_w_r;
  assign out_divide_fault = out_fault_r;

`ifndef SYNTHESIS
  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_divide_fault |-> out_x == 0 && out_y == 0 && out_z == 0 && out_w == 0)
    else $error("fault result with nonzero outputs");
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");
  a_stall_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while output side free");
`endif

endmodule

[dv/homogeneous_vertex_transform_tb.sv]
`timescale 1ns / 1ps
module homogeneous_vertex_transform_tb;
  import hvt_pkg::*;

  localparam int FB = FRAC_BITS_DEF;
  localparam int PIPE_LAT = 5 + DIV_LAT;
  localparam longint CYCLE_LIMIT = 2000000;

  typedef struct packed {
    fx_t  x;
    fx_t  y;
    fx_t  z;
    fx_t  w;
    logic fault;
  } vertex_out_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  fx_t in_x = '0, in_y = '0, in_z = '0, in_w = '0;
  logic in_project_point = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  fx_t out_x, out_y, out_z, out_w;
  logic out_divide_fault;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [63:0] cfg_data = '0;

  homogeneous_vertex_transform dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow of the matrix registers
  logic [63:0] matrix_shadow [8];
  vertex_out_t expected_vertices [$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  longint cycle_count = 0;

  // element m(row, col) from the shadow registers
  function automatic logic signed [63:0] elem(int row, int col);
    logic [63:0] r;
    r = matrix_shadow[row * 2 + col / 2];
    return (col % 2) ? 64'(signed'(r[63:32])) : 64'(signed'(r[31:0]));
  endfunction

  // rounded, saturated column dot product
  function automatic fx_t column_dot(logic signed [63:0] v [4], int col);
    logic signed [129:0] acc;
    acc = 0;
    for (int i = 0; i < 4; i++) acc += 130'(v[i] * elem(i, col));
    acc += 130'(1) <<< (FB - 1);
    acc = acc >>> FB;
    if (acc > 130'(FX_MAX)) return FX_MAX;
    if (acc < 130'(FX_MIN)) return FX_MIN;
    return acc[31:0];
  endfunction

  function automatic vertex_out_t transform_vertex(fx_t x, fx_t y, fx_t z, fx_t w,
                                                   logic proj);
    logic signed [63:0] v [4];
    fx_t r [4];
    logic signed [63:0] num, quo;
    vertex_out_t o;
    v[0] = x; v[1] = y; v[2] = z;
    v[3] = proj ? 64'sd1 <<< FB : 64'(w);
    for (int j = 0; j < 4; j++) r[j] = column_dot(v, j);
    o.fault = 1'b0;
    if (proj) begin
      if (r[3] == 0) begin
        o.fault = 1'b1;
        for (int j = 0; j < 4; j++) r[j] = '0;
      end else begin
        for (int j = 0; j < 3; j++) begin
          num = 64'(r[j]) <<< FB;
          quo = num / 64'(r[3]);
          if (quo > 64'(FX_MAX)) r[j] = FX_MAX;
          else if (quo < 64'(FX_MIN)) r[j] = FX_MIN;
          else r[j] = quo[31:0];
        end
      end
    end
    o.x = r[0]; o.y = r[1]; o.z = r[2]; o.w = r[3];
    return o;
  endfunction

  // receiver stall pattern
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // result checker
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t timeout", $time);
      $display("homogeneous_vertex_transform_tb: FAIL");
      $finish;
    end
    if (rst_n && out_valid && !out_stall) begin
      vertex_out_t got, exp_v;
      got = '{out_x, out_y, out_z, out_w, out_divide_fault};
      if (expected_vertices.size() == 0) begin
        $display("%0t unexpected result %h", $time, got);
        errors++;
      end else begin
        exp_v = expected_vertices.pop_front();
        if (got.x !== exp_v.x) begin
          $display("%0t x exp %h got %h", $time, exp_v.x, got.x); errors++;
        end
        if (got.y !== exp_v.y) begin
          $display("%0t y exp %h got %h", $time, exp_v.y, got.y); errors++;
        end
        if (got.z !== exp_v.z) begin
          $display("%0t z exp %h got %h", $time, exp_v.z, got.z); errors++;
        end
        if (got.w !== exp_v.w) begin
          $display("%0t w exp %h got %h", $time, exp_v.w, got.w); errors++;
        end
        if (got.fault !== exp_v.fault) begin
          $display("%0t fault exp %b got %b", $time, exp_v.fault, got.fault);
          errors++;
        end
      end
    end
  end

  // send one vertex request; valid stays up for a following request
  task automatic send_vertex(fx_t x, fx_t y, fx_t z, fx_t w, logic proj);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_x <= x; in_y <= y; in_z <= z; in_w <= w;
    in_project_point <= proj;
    do @(posedge clk); while (in_stall);
    expected_vertices.push_back(transform_vertex(x, y, z, w, proj));
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_vertices.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx < CFG_ADDR_W'(NUM_REGS)) matrix_shadow[idx[2:0]] = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic fx_t rand_fx();
    case ($urandom_range(5))
      0: return FX_MAX;
      1: return FX_MIN;
      2: return fx_t'($urandom_range(0, 1 << 20)) - fx_t'(1 << 19);
      3: return fx_t'(32'sd1 <<< FB);
      default: return fx_t'($urandom);
    endcase
  endfunction

  // mostly modest matrix entries so projections stay in range
  function automatic logic [31:0] rand_elem();
    if ($urandom_range(3) == 0) return $urandom;
    return 32'($urandom_range(0, 1 << 18)) - 32'(1 << 17);
  endfunction

  task automatic load_random_matrix();
    for (int i = 0; i < NUM_REGS; i++)
      write_reg(CFG_ADDR_W'(i), {rand_elem(), rand_elem()});
  endtask

  task automatic test_identity();
    send_vertex(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000, 32'sh0001_0000, 1'b0);
    send_vertex(FX_MAX, FX_MIN, FX_MAX, FX_MIN, 1'b0);
    send_vertex(FX_MIN, FX_MAX, FX_MIN, FX_MAX, 1'b1);
    send_vertex('0, '0, '0, '0, 1'b0);
    send_vertex(-32'sd1, -32'sd1, -32'sd1, -32'sd1, 1'b0);
    send_vertex(32'sh0000_8000, -32'sh0000_8000, 32'sd1, 32'sd1, 1'b1);
    drain();
  endtask

  // doubling identity saturates
  task automatic test_saturation();
    write_reg(CFG_ADDR_W'(REG_ROW0_C01), {32'h0, 32'h0002_0000});
    send_vertex(FX_MAX, 0, 0, 0, 1'b0);
    send_vertex(FX_MIN, 0, 0, 0, 1'b0);
    drain();
  endtask

  // zero w in project mode: clear column 3
  task automatic test_zero_w();
    write_reg(CFG_ADDR_W'(REG_ROW3_C23), 64'h0);
    send_vertex(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, 1'b1);
    send_vertex(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, 1'b0);
    drain();
  endtask

  // tiny w: divide overflow, and rounding of half LSB
  task automatic test_divide_edges();
    write_reg(CFG_ADDR_W'(REG_ROW3_C23), {32'sd1, 32'h0});
    send_vertex(32'sh0100_0000, -32'sh0100_0000, 32'sd0, 0, 1'b1);
    drain();
    write_reg(CFG_ADDR_W'(REG_ROW3_C23), {32'h0000_8000, 32'h0000_8000});
    send_vertex(32'sd1, 32'sd3, -32'sd1, 32'sd1, 1'b0);
    send_vertex(-32'sh0003_0000, 32'sh0001_0000, 0, 0, 1'b1);
    drain();
  endtask

  // extreme matrix: all ones bits, then max in even columns and min in odd columns
  task automatic test_extreme_matrix();
    for (int i = 0; i < NUM_REGS; i++)
      write_reg(CFG_ADDR_W'(i), 64'hFFFF_FFFF_FFFF_FFFF);
    send_vertex(FX_MAX, FX_MAX, FX_MAX, FX_MAX, 1'b0);
    send_vertex(FX_MIN, FX_MIN, FX_MIN, FX_MIN, 1'b1);
    drain();
    for (int i = 0; i < NUM_REGS; i++) write_reg(CFG_ADDR_W'(i), {FX_MIN, FX_MAX});
    send_vertex(FX_MAX, FX_MIN, 32'sd1, FX_MAX, 1'b0);
    send_vertex(FX_MIN, FX_MIN, FX_MIN, 0, 1'b1);
    drain();
  endtask

  // out-of-range index is ignored
  task automatic test_bad_index();
    write_reg(4'd8, 64'h1234);
    write_reg(4'd15, 64'hFFFF);
    send_vertex(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, 1'b1);
    drain();
  endtask

  task automatic test_random_phase(int n, int idle_pct, int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    load_random_matrix();
    for (int k = 0; k < n; k++) begin
      send_vertex(rand_fx(), rand_fx(), rand_fx(), rand_fx(), 1'($urandom));
      // sender holds off until the pipe is empty
      if (k == n / 2) begin
        in_valid <= 1'b0;
        while (expected_vertices.size() != 0) @(negedge clk);
      end
    end
    drain();
    recv_stall_pct = 0;
  endtask

  initial begin
    for (int i = 0; i < NUM_REGS; i++) matrix_shadow[i] = '0;
    matrix_shadow[0] = 64'(1) << FB;
    matrix_shadow[2] = (64'(1) << FB) << 32;
    matrix_shadow[5] = 64'(1) << FB;
    matrix_shadow[7] = (64'(1) << FB) << 32;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_identity();
    test_saturation();
    test_zero_w();
    test_divide_edges();
    test_extreme_matrix();
    test_bad_index();
    test_random_phase(300, 0, 0);
    test_random_phase(250, 84, 0);
    test_random_phase(250, 0, 84);
    test_random_phase(250, 27, 27);
    if (errors == 0) begin
      $display("homogeneous_vertex_transform_tb: PASS");
    end else begin
      $display("homogeneous_vertex_transform_tb: FAIL");
    end
    $finish;
  end

endmodule
